>>> rtl/core/lwcp_pkg.sv
// ----------------------------------------------------------------------------
// lwcp_pkg
// Shared types and fixed widths of the lagged weighted cross-product core.
// ----------------------------------------------------------------------------
package lwcp_pkg;

  localparam int SMP_W  = 16;  // sample and weight port width
  localparam int PROD_W = 32;  // row term a[i] * wd
  localparam int MAC_W  = 48;  // a[i] * wd * b[j]
  localparam int ACC_W  = 64;
  localparam int DEN_W  = 63;
  localparam int IDX_W  = 3;

  // register indexes of the configuration port
  localparam logic [0:0] REG_LAG  = 1'b0;
  localparam logic [0:0] REG_COLS = 1'b1;

  // row term travelling down the column cells
  typedef struct packed {
    logic                     vld;
    logic [IDX_W-1:0]         row;
    logic signed [PROD_W-1:0] p;
  } lwcp_tap_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MAC,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

>>> rtl/core/lwcp_dly.sv
// ----------------------------------------------------------------------------
// lwcp_dly
// Circular delay store of past rows and weights, one write and one read port.
// ----------------------------------------------------------------------------
module lwcp_dly #(
  parameter int DEPTH = 31,
  parameter int AW    = 5,
  parameter int DW    = 144
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/lwcp_cell.sv
// ----------------------------------------------------------------------------
// lwcp_cell
// One column cell: holds b[j] and the eight accumulators of its column,
// multiplies each passing row term and hands it on to the next cell.
// ----------------------------------------------------------------------------
module lwcp_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           ld_b,
  input  logic signed [lwcp_pkg::SMP_W-1:0] b_in,
  input  logic                           clr,
  input  lwcp_pkg::lwcp_tap_t            tap_i,
  output lwcp_pkg::lwcp_tap_t            tap_o,
  input  logic [lwcp_pkg::IDX_W-1:0]     rd_row,
  output logic [lwcp_pkg::ACC_W-1:0]     rd_acc
);
  import lwcp_pkg::*;

  logic signed [SMP_W-1:0] b_r;
  lwcp_tap_t               tap_r;
  logic signed [MAC_W-1:0] prod_r;
  logic                    pv_r;
  logic [IDX_W-1:0]        prow_r;
  logic signed [ACC_W-1:0] acc_r [8];

  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] sum;
  logic signed [ACC_W-1:0] acc_cur;
  logic                    ovf;

  always_ff @(posedge clk) begin
    if (ld_b) begin
      b_r <= b_in;
    end
    prod_r    <= MAC_W'($signed(tap_i.p) * b_r);
    prow_r    <= tap_i.row;
    tap_r.row <= tap_i.row;
    tap_r.p   <= tap_i.p;
    if (!rst_n) begin
      tap_r.vld <= 1'b0;
      pv_r      <= 1'b0;
    end else begin
      tap_r.vld <= tap_i.vld;
      pv_r      <= tap_i.vld;
    end
  end

  assign acc_cur  = acc_r[prow_r];
  assign prod_ext = ACC_W'(prod_r);
  assign sum      = acc_cur + prod_ext;
  assign ovf      = (acc_cur[ACC_W-1] == prod_ext[ACC_W-1]) &&
                    (sum[ACC_W-1] != acc_cur[ACC_W-1]);

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      for (int i = 0; i < 8; i++) begin
        acc_r[i] <= '0;
      end
    end else if (pv_r) begin
      if (ovf) begin
        acc_r[prow_r] <= prod_ext[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                           : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
        acc_r[prow_r] <= sum;
      end
    end
  end

  assign tap_o  = tap_r;
  assign rd_acc = acc_r[rd_row];

endmodule

>>> rtl/core/lwcp_div.sv
// ----------------------------------------------------------------------------
// lwcp_div
// Restoring divider, one quotient bit a cycle: 64-bit signed accumulator by
// 63-bit denominator, quotient truncated and saturated to 32 bits.
// ----------------------------------------------------------------------------
module lwcp_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic [lwcp_pkg::ACC_W-1:0]    num,
  input  logic [lwcp_pkg::DEN_W-1:0]    den,
  output logic                          done,
  output logic [31:0]                   q
);
  import lwcp_pkg::*;

  localparam int DV_W = DEN_W + 32;

  logic [ACC_W-1:0] rem_r;
  logic [DV_W-1:0]  dv_r;
  logic [32:0]      q_r;
  logic [5:0]       k_r;
  logic             run_r;
  logic             done_r;
  logic             neg_r;
  logic             ovf_r;

  logic [ACC_W-1:0] mag;
  logic             fits;

  assign mag  = num[ACC_W-1] ? (~num + 64'd1) : num;
  assign fits = {{(DV_W-ACC_W){1'b0}}, rem_r} >= dv_r;

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= mag;
      dv_r  <= {den, 32'd0};
      q_r   <= '0;
      neg_r <= num[ACC_W-1];
      // quotient needs more than 33 bits: saturates whatever follows
      ovf_r <= {32'd0, mag[ACC_W-1:33]} >= den;
    end else if (run_r) begin
      if (fits) begin
        rem_r <= rem_r - dv_r[ACC_W-1:0];
      end
      q_r  <= {q_r[31:0], fits};
      dv_r <= dv_r >> 1;
    end
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else if (go) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      k_r    <= 6'd32;
    end else begin
      done_r <= run_r && (k_r == 6'd0);
      if (run_r) begin
        if (k_r == 6'd0) begin
          run_r <= 1'b0;
        end else begin
          k_r <= k_r - 6'd1;
        end
      end
    end
  end

  always_comb begin
    if (neg_r) begin
      if (ovf_r || (q_r > 33'h080000000)) begin
        q = 32'h80000000;
      end else begin
        q = 32'(~q_r + 33'd1);
      end
    end else begin
      if (ovf_r || (q_r > 33'h07FFFFFFF)) begin
        q = 32'h7FFFFFFF;
      end else begin
        q = q_r[31:0];
      end
    end
  end

  assign done = done_r;

endmodule

>>> rtl/core/lagged_weighted_cross_product_core.sv
// ----------------------------------------------------------------------------
// lagged_weighted_cross_product_core
// Weighted lagged cross-product accumulator with normalised matrix readout.
// ----------------------------------------------------------------------------
// A sample is taken when start is high and busy is low; busy then stays high
// while the sample is accumulated, through the delay-store read and the row
// terms running down the chain of column cells with the pipeline drained
// behind them, so no new sample is taken before the last is through. On a
// sample marked final_sample the core then emits the cols_in_use square in
// row-major order, one entry per out_strobe pulse; each entry takes a load,
// a division at one quotient bit a cycle in the shared divider, and a
// transfer, with the division skipped when the denominator is zero. Results
// cannot be held off: the receiver must take every out_strobe transfer.
// Configuration writes are always ready and should only be made while busy
// is low.
// ----------------------------------------------------------------------------
module lagged_weighted_cross_product_core #(
  parameter int NUM_COLS    = 8,
  parameter int LAG_MAX     = 31,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [lwcp_pkg::SMP_W-1:0]        in_u_0,
  input  logic [lwcp_pkg::SMP_W-1:0]        in_u_1,
  input  logic [lwcp_pkg::SMP_W-1:0]        in_u_2,
  input  logic [lwcp_pkg::SMP_W-1:0]        in_u_3,
  input  logic [lwcp_pkg::SMP_W-1:0]        in_u_4,
  input  logic [lwcp_pkg::SMP_W-1:0]        in_u_5,
  input  logic [lwcp_pkg::SMP_W-1:0]        in_u_6,
  input  logic [lwcp_pkg::SMP_W-1:0]        in_u_7,
  input  logic [lwcp_pkg::SMP_W-1:0]        in_weight,
  input  logic                              in_block_start,
  input  logic                              in_final_sample,
  output logic                              out_strobe,
  output logic [lwcp_pkg::IDX_W-1:0]        out_row_index,
  output logic [lwcp_pkg::IDX_W-1:0]        out_col_index,
  output logic signed [31:0]                out_value,
  output logic [lwcp_pkg::DEN_W-1:0]        out_denominator,
  output logic                              out_valid_res,
  output logic                              out_last_entry,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [0:0]                        cfg_index,
  input  logic [5:0]                        cfg_data
);
  import lwcp_pkg::*;

  localparam int DEPTH   = (LAG_MAX > 0) ? LAG_MAX : 1;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW      = ((AW > 6) ? AW : 6) + 1;
  localparam int ROW_W   = NUM_COLS * SMP_W;
  localparam int DW      = ROW_W + SMP_W;
  localparam int MAC_LEN = 2 * NUM_COLS + 3;
  localparam int PH_W    = $clog2(MAC_LEN + 1);
  localparam int SH      = SMP_W - SAMPLE_BITS;

  // --- configuration registers ---
  logic signed [5:0] lag_r;
  logic [3:0]        cols_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lag_r  <= '0;
      cols_r <= 4'd8;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LAG:  lag_r  <= cfg_data;
        REG_COLS: cols_r <= cfg_data[3:0];
        default:  ;
      endcase
    end
  end

  // --- input conditioning: low SAMPLE_BITS bits as two's complement ---
  logic [SMP_W-1:0]        u_arr [8];
  logic signed [SMP_W-1:0] u_sx  [8];
  logic signed [SMP_W-1:0] w_sx;
  logic [SMP_W-1:0]        w_sh;

  assign u_arr[0] = in_u_0;
  assign u_arr[1] = in_u_1;
  assign u_arr[2] = in_u_2;
  assign u_arr[3] = in_u_3;
  assign u_arr[4] = in_u_4;
  assign u_arr[5] = in_u_5;
  assign u_arr[6] = in_u_6;
  assign u_arr[7] = in_u_7;

  for (genvar c = 0; c < 8; c++) begin : g_sx
    logic [SMP_W-1:0] u_sh;
    assign u_sh    = u_arr[c] << SH;
    assign u_sx[c] = $signed(u_sh) >>> SH;
  end
  assign w_sh = in_weight << SH;
  assign w_sx = $signed(w_sh) >>> SH;

  // --- sequencer state ---
  state_t            state_r, state_nxt;
  logic [PH_W-1:0]   ph_r;
  logic [15:0]       cnt_r;
  logic [AW-1:0]     wp_r;
  logic              paired_r, use_dly_r, neg_r, final_r;
  logic [IDX_W-1:0]  ei_r, ej_r;
  logic [DEN_W-1:0]  denom_r;
  logic [31:0]       val_r;

  logic signed [SMP_W-1:0] cur_r [8];
  logic signed [SMP_W-1:0] a_r   [8];
  logic signed [SMP_W-1:0] w_r;
  logic signed [SMP_W-1:0] wd_r;

  // control pulses out of the state decode (accept to clr) and status flags
  logic accept, ld_b, feed, div_go, clr, last_ph, ok, last_ent;
  logic div_done;
  logic [31:0] div_q;

  // --- pairing decision at accept ---
  logic [5:0]    lag_mag;
  logic [15:0]   cnt_eff;
  logic          pair_now;
  logic [RW-1:0] wp_ext, m_ext, rd_ext;
  logic [AW-1:0] rd_addr;
  logic [DW-1:0] wdata, rdata;

  assign lag_mag  = lag_r[5] ? 6'(~lag_r + 6'sd1) : 6'(lag_r);
  assign cnt_eff  = in_block_start ? 16'd0 : cnt_r;
  assign pair_now = (lag_mag == 6'd0) ||
                    (({3'd0, lag_mag} <= 9'(LAG_MAX)) && (cnt_eff >= {10'd0, lag_mag}));
  assign wp_ext   = RW'(wp_r);
  assign m_ext    = RW'(lag_mag);
  assign rd_ext   = (wp_ext >= m_ext) ? (wp_ext - m_ext) : (wp_ext + RW'(DEPTH) - m_ext);
  assign rd_addr  = rd_ext[AW-1:0];

  always_comb begin
    wdata = '0;
    for (int c = 0; c < NUM_COLS; c++) begin
      wdata[c*SMP_W +: SMP_W] = u_sx[c];
    end
    wdata[ROW_W +: SMP_W] = w_sx;
  end

  lwcp_dly #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_dly (
    .clk   (clk),
    .we    (accept),
    .waddr (wp_r),
    .wdata (wdata),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // --- orientation: delayed row is a for positive lag, b for negative ---
  logic signed [SMP_W-1:0] d_row [8];
  logic signed [SMP_W-1:0] a_sel [8];
  logic signed [SMP_W-1:0] b_sel [8];
  logic signed [SMP_W-1:0] d_w;

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      d_row[c] = (c < NUM_COLS) ? $signed(rdata[(c % NUM_COLS)*SMP_W +: SMP_W]) : '0;
      a_sel[c] = (use_dly_r && !neg_r) ? d_row[c] : cur_r[c];
      b_sel[c] = (use_dly_r &&  neg_r) ? d_row[c] : cur_r[c];
    end
  end
  assign d_w = $signed(rdata[ROW_W +: SMP_W]);

  // --- registers of the sequencer ---
  logic [IDX_W-1:0]        kf;
  logic signed [PROD_W-1:0] p_head;
  logic [31:0]             sq;
  logic [ACC_W-1:0]        dsum;
  lwcp_tap_t               head_r;
  logic [3:0]              r_side;
  logic [IDX_W-1:0]        r_last;

  assign kf     = ph_r[IDX_W-1:0];
  assign p_head = PROD_W'(a_r[kf] * wd_r);
  assign sq     = 32'(wd_r * wd_r);
  assign dsum   = {1'b0, denom_r} + {32'd0, sq};
  assign r_side = (cols_r == 4'd0) ? 4'd1 :
                  ((cols_r > 4'(NUM_COLS)) ? 4'(NUM_COLS) : cols_r);
  assign r_last = 3'(r_side - 4'd1);
  assign ok       = denom_r != '0;
  assign last_ent = (ei_r == r_last) && (ej_r == r_last);
  assign last_ph  = ph_r == PH_W'(MAC_LEN - 1);

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int c = 0; c < 8; c++) begin
        cur_r[c] <= u_sx[c];
      end
      w_r       <= w_sx;
      paired_r  <= pair_now;
      use_dly_r <= lag_mag != 6'd0;
      neg_r     <= lag_r[5];
      final_r   <= in_final_sample;
    end
    if (ld_b) begin
      for (int c = 0; c < 8; c++) begin
        a_r[c] <= a_sel[c];
      end
      wd_r <= use_dly_r ? d_w : w_r;
    end
    head_r.row <= kf;
    head_r.p   <= p_head;
    if (div_done) begin
      val_r <= div_q;
    end else if (div_go == 1'b0 && state_r == ST_LOAD) begin
      val_r <= '0;
    end

    if (!rst_n) begin
      state_r    <= ST_IDLE;
      ph_r       <= '0;
      cnt_r      <= '0;
      wp_r       <= '0;
      ei_r       <= '0;
      ej_r       <= '0;
      denom_r    <= '0;
      head_r.vld <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      head_r.vld <= feed;
      if (accept) begin
        cnt_r <= in_final_sample ? 16'd0 :
                 ((cnt_eff == 16'hFFFF) ? cnt_eff : cnt_eff + 16'd1);
        wp_r  <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      end
      if (state_r == ST_MAC) begin
        ph_r <= last_ph ? '0 : ph_r + PH_W'(1);
        if (ph_r == '0 && paired_r) begin
          denom_r <= (dsum > {1'b0, {DEN_W{1'b1}}}) ? {DEN_W{1'b1}} : dsum[DEN_W-1:0];
        end
      end
      if (state_r == ST_MAC && last_ph) begin
        ei_r <= '0;
        ej_r <= '0;
      end
      if (state_r == ST_OUT) begin
        if (last_ent) begin
          denom_r <= '0;
        end else if (ej_r == r_last) begin
          ej_r <= '0;
          ei_r <= ei_r + 3'd1;
        end else begin
          ej_r <= ej_r + 3'd1;
        end
      end
    end
  end

  // --- next state ---
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_MAC;
      ST_MAC:  if (last_ph) state_nxt = final_r ? ST_LOAD : ST_IDLE;
      ST_LOAD: state_nxt = ok ? ST_DIV : ST_OUT;
      ST_DIV:  if (div_done) state_nxt = ST_OUT;
      ST_OUT:  state_nxt = last_ent ? ST_IDLE : ST_LOAD;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --- state decode ---
  always_comb begin
    busy       = 1'b1;
    accept     = 1'b0;
    ld_b       = 1'b0;
    feed       = 1'b0;
    div_go     = 1'b0;
    clr        = 1'b0;
    out_strobe = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        busy   = 1'b0;
        accept = start;
      end
      ST_READ: ld_b = 1'b1;
      ST_MAC:  feed = paired_r && (ph_r < PH_W'(NUM_COLS));
      ST_LOAD: div_go = ok;
      ST_DIV:  ;
      ST_OUT: begin
        out_strobe = 1'b1;
        clr        = last_ent;
      end
      default: ;
    endcase
  end

  // --- chain of column cells ---
  lwcp_tap_t        tap [NUM_COLS+1];
  logic [ACC_W-1:0] rd_acc [8];

  assign tap[0] = head_r;

  for (genvar j = 0; j < 8; j++) begin : g_col
    if (j < NUM_COLS) begin : g_cell
      lwcp_cell u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .ld_b   (ld_b),
        .b_in   (b_sel[j]),
        .clr    (clr),
        .tap_i  (tap[j]),
        .tap_o  (tap[j+1]),
        .rd_row (ei_r),
        .rd_acc (rd_acc[j])
      );
    end else begin : g_none
      assign rd_acc[j] = '0;
    end
  end

  // --- shared divider for the readout ---
  lwcp_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (div_go),
    .num  (rd_acc[ej_r]),
    .den  (denom_r),
    .done (div_done),
    .q    (div_q)
  );

  // --- result ports ---
  assign out_row_index   = ei_r;
  assign out_col_index   = ej_r;
  assign out_value       = ok ? val_r : 32'd0;
  assign out_denominator = denom_r;
  assign out_valid_res   = ok;
  assign out_last_entry  = last_ent;

endmodule

>>> rtl/core/lwcp_chk.sv
// ----------------------------------------------------------------------------
// lwcp_chk
// Port-level checks of the cross-product core, bound to the top level.
// ----------------------------------------------------------------------------
module lwcp_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_strobe,
  input logic [31:0] out_value,
  input logic [62:0] out_denominator,
  input logic        out_valid_res,
  input logic        out_last_entry
);

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result transfer while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted sample did not raise busy");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_valid_res) |-> (out_value == 32'd0 && out_denominator == 63'd0))
    else $error("invalid entry carries data");

  a_valid_den: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_valid_res) |-> (out_denominator != 63'd0))
    else $error("valid entry with zero denominator");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last_entry) |=> (!out_strobe && !busy))
    else $error("transfer after last entry");

endmodule

bind lagged_weighted_cross_product_core lwcp_chk u_lwcp_chk (.*);
